// File: design/two_level_page_table_map_defines.svh
// Assertion macros for the two-level page table block.
// Clocked on clk, disabled while rst is high; used by the top level only.
`ifndef TWO_LEVEL_PAGE_TABLE_MAP_DEFINES_SVH
`define TWO_LEVEL_PAGE_TABLE_MAP_DEFINES_SVH

// Same-cycle implication.
`define TLPT_ASSERT_IMPL(name, cond, prop) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("tlpt: same-cycle check failed");

// Next-cycle implication.
`define TLPT_ASSERT_NEXT(name, cond, prop) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("tlpt: next-cycle check failed");

`endif

// File: design/tlpt_pkg.sv
// Shared types and constants for the two-level page table block.
// No dependencies.
package tlpt_pkg;

  localparam int TABLE_POOL_DEF = 16;
  localparam int DIR_ENTRIES    = 1024;
  localparam int PT_ENTRIES     = 1024;
  localparam int IDX_W          = 10;
  localparam int OFFSET_W       = 12;
  localparam int FRAME_W        = 32 - OFFSET_W;

  localparam logic [1:0] OP_MAP   = 2'd0;
  localparam logic [1:0] OP_UNMAP = 2'd1;
  localparam logic [1:0] OP_XLATE = 2'd2;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] virt_addr;
    logic [31:0] phys_addr_in;
    logic [11:0] page_flags;
  } tlpt_req_t;

  typedef struct packed {
    logic        ok;
    logic [31:0] phys_addr_out;
  } tlpt_rsp_t;

endpackage

// File: design/two_level_page_table_map.sv
// Two-level page table: directory RAM plus a pool of second-level tables in one RAM.
// A request is looked up in the directory and answered; a translate whose directory entry is present
// also reads its table, and a map that allocates a table first sweeps it (one page entry cleared per
// cycle on the single table RAM port). A new request is taken only in the idle state, and only once
// the previous result can leave its register. Reset: a pass clears the directory, no request taken.
// Depends on tlpt_pkg, tlpt_ram and two_level_page_table_map_defines.svh.
`include "two_level_page_table_map_defines.svh"

module two_level_page_table_map import tlpt_pkg::*; #(
  parameter int TABLE_POOL = TABLE_POOL_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_ready,
  input  tlpt_req_t req,
  output logic      rsp_valid,
  input  logic      rsp_ready,
  output tlpt_rsp_t rsp
);

  localparam int TW  = (TABLE_POOL > 1) ? $clog2(TABLE_POOL) : 1;
  localparam int UW  = $clog2(TABLE_POOL + 1);
  localparam int SAW = $clog2(TABLE_POOL * PT_ENTRIES);
  localparam int DAW = $clog2(DIR_ENTRIES);
  localparam int DW  = TW + 1;

  localparam logic [2:0] S_INIT   = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_LOOKUP = 3'd2;
  localparam logic [2:0] S_CLEAR  = 3'd3;
  localparam logic [2:0] S_TREAD  = 3'd4;

  logic [2:0]       state, state_next;
  logic [IDX_W-1:0] cnt, cnt_next;
  logic [UW-1:0]    tables_used, tables_used_next;
  logic [TW-1:0]    tbl, tbl_next;
  tlpt_req_t        cur, cur_next;
  tlpt_rsp_t        res, res_next;
  logic             res_valid, res_load, res_move;

  logic             dir_we;
  logic [DAW-1:0]   dir_addr;
  logic [DW-1:0]    dir_wdata, dir_rdata;
  logic             st_we;
  logic [SAW-1:0]   st_addr;
  logic [31:0]      st_wdata, st_rdata;

  logic [IDX_W-1:0] cur_ti;
  logic [DAW-1:0]   cur_di;
  logic             dir_present;
  logic [TW-1:0]    dir_tbl;
  logic [31:0]      entry;

  assign cur_ti      = cur.virt_addr[21:12];
  assign cur_di      = cur.virt_addr[31:22];
  assign dir_present = dir_rdata[TW];
  assign dir_tbl     = dir_rdata[TW-1:0];
  assign entry       = {cur.phys_addr_in[31:OFFSET_W], cur.page_flags};

  assign res_move  = res_valid && (!rsp_valid || rsp_ready);
  assign req_ready = (state == S_IDLE) && (!res_valid || res_move);

  tlpt_ram #(.WIDTH(DW), .DEPTH(DIR_ENTRIES)) u_dir (
    .clk   (clk),
    .we    (dir_we),
    .addr  (dir_addr),
    .wdata (dir_wdata),
    .rdata (dir_rdata)
  );

  tlpt_ram #(.WIDTH(32), .DEPTH(TABLE_POOL * PT_ENTRIES)) u_store (
    .clk   (clk),
    .we    (st_we),
    .addr  (st_addr),
    .wdata (st_wdata),
    .rdata (st_rdata)
  );

  always_comb begin
    state_next       = state;
    cnt_next         = cnt;
    tables_used_next = tables_used;
    tbl_next         = tbl;
    cur_next         = cur;
    res_next         = '0;
    res_load         = 1'b0;
    dir_we           = 1'b0;
    dir_addr         = req.virt_addr[31:22];
    dir_wdata        = '0;
    st_we            = 1'b0;
    st_addr          = SAW'({dir_tbl, cur_ti});
    st_wdata         = '0;

    unique case (state)
      S_INIT: begin
        dir_we    = 1'b1;
        dir_addr  = DAW'(cnt);
        cnt_next  = cnt + 1'b1;
        if (cnt == '1) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        // directory read is launched on the accepting edge
        if (req_valid && req_ready) begin
          cur_next   = req;
          state_next = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        state_next = S_IDLE;
        res_load   = 1'b1;
        unique case (cur.opcode)
          OP_MAP: begin
            if (dir_present) begin
              st_we       = 1'b1;
              st_wdata    = entry;
              res_next.ok = 1'b1;
            end else if (tables_used < UW'(TABLE_POOL)) begin
              // claim the next pool table, then sweep it clear
              dir_we           = 1'b1;
              dir_addr         = cur_di;
              dir_wdata        = {1'b1, tables_used[TW-1:0]};
              tbl_next         = tables_used[TW-1:0];
              tables_used_next = tables_used + 1'b1;
              cnt_next         = '0;
              res_load         = 1'b0;
              state_next       = S_CLEAR;
            end
          end
          OP_UNMAP: begin
            if (dir_present) begin
              st_we       = 1'b1;
              res_next.ok = 1'b1;
            end
          end
          OP_XLATE: begin
            if (dir_present) begin
              res_load   = 1'b0;
              state_next = S_TREAD;
            end
          end
          default: begin
          end
        endcase
      end
      S_CLEAR: begin
        // the mapped entry lands during the sweep instead of zero
        st_we    = 1'b1;
        st_addr  = SAW'({tbl, cnt});
        st_wdata = (cnt == cur_ti) ? entry : '0;
        cnt_next = cnt + 1'b1;
        if (cnt == '1) begin
          res_next.ok = 1'b1;
          res_load    = 1'b1;
          state_next  = S_IDLE;
        end
      end
      S_TREAD: begin
        res_load   = 1'b1;
        state_next = S_IDLE;
        if (st_rdata[0]) begin
          res_next.ok            = 1'b1;
          res_next.phys_addr_out = {st_rdata[31:OFFSET_W], cur.virt_addr[OFFSET_W-1:0]};
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_INIT;
      cnt         <= '0;
      tables_used <= '0;
      res_valid   <= 1'b0;
      rsp_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      cnt         <= cnt_next;
      tables_used <= tables_used_next;
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (res_move) begin
        res_valid <= 1'b0;
      end
      if (res_move) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur <= cur_next;
    tbl <= tbl_next;
    if (res_load) begin
      res <= res_next;
    end
    if (res_move) begin
      rsp <= res;
    end
  end

  `TLPT_ASSERT_IMPL(a_pool_bound, 1'b1, tables_used <= UW'(TABLE_POOL))
  `TLPT_ASSERT_IMPL(a_lookup_after_accept, state == S_LOOKUP, $past(req_valid && req_ready))
  `TLPT_ASSERT_IMPL(a_addr_needs_ok, rsp_valid, rsp.ok || (rsp.phys_addr_out == '0))
  `TLPT_ASSERT_NEXT(a_alloc_done, (state == S_CLEAR) && (cnt == '1), res_valid && res.ok)

endmodule

// File: design/tlpt_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
module tlpt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
